FILE: hw/rtl/dq_pkg.sv
// Package for the double-ended queue: sizes, operation codes and cell control type.
`default_nettype none

package dq_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Fixed field widths of the request and response payloads
    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } op_t;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } dq_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dq_req_if.sv
// Request channel of the double-ended queue: operation and push word.
`default_nettype none

interface dq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [dq_pkg::OP_W-1:0]                operation;
    logic [dq_pkg::WORD_W-1:0]              push_value;

    modport source (output valid, output operation, output push_value, input ready);
    modport sink   (input valid, input operation, input push_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dq_rsp_if.sv
// Response channel of the double-ended queue: success flag, word read, occupancy.
`default_nettype none

interface dq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   success;
    logic [dq_pkg::WORD_W-1:0]              read_value;
    logic [dq_pkg::OCC_W-1:0]               occupancy;

    modport source (output valid, output success, output read_value, output occupancy,
                    input ready);
    modport sink   (input valid, input success, input read_value, input occupancy,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: cell row, operation decode, response stage.
// The queue is a row of DEPTH cells with the front always in cell 0; one
// request can be accepted per cycle while the skid register is empty. A front
// push or pop shifts the whole row by one cell, a rear push or pop acts on the
// cell at the occupied/free boundary, and the rear word is picked by an and-or
// over the cells. Responses leave through an output register backed by a skid
// register, so a request is still accepted while one response waits; the
// request side stalls only when both are full. Each response is registered
// in the output register, or in the skid register while that one is held.
// No clearing pass is needed after reset.
`default_nettype none

module double_ended_queue (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dq_req_if.sink      req,
    dq_rsp_if.source    rsp
);

    localparam int DEPTH = dq_pkg::DEPTH;
    localparam int DW    = dq_pkg::DATA_WIDTH;
    localparam int CW    = dq_pkg::CNT_W;

    typedef struct packed {
        logic                          success;
        logic [dq_pkg::WORD_W-1:0]     read_value;
        logic [dq_pkg::OCC_W-1:0]      occupancy;
    } rsp_t;

    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       cnt_next;
    logic                full;
    logic                empty;
    logic                accept;
    dq_pkg::dq_ctrl_t    ctrl;
    logic                ok;
    logic                rd_front;
    logic                rd_rear;
    logic [DW-1:0]       push_data;
    logic [DW-1:0]       rear_data;
    logic [DW-1:0]       rd_data;
    logic [63:0]         push_ext;
    logic [63:0]         rd_ext;
    rsp_t                new_rsp;

    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_last;
    logic [DW-1:0]       cell_data [DEPTH];
    logic [DEPTH+1:0]    chain_valid;
    logic [DW-1:0]       chain_data [DEPTH+2];

    logic                out_valid_reg;
    rsp_t                out_reg;
    logic                skid_valid_reg;
    rsp_t                skid_reg;

    assign full   = (cnt_reg == CW'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign req.ready = !skid_valid_reg;
    assign accept = req.valid && req.ready;

    assign push_ext  = 64'(req.push_value);
    assign push_data = push_ext[DW-1:0];

    // Operation decode; refused and unknown operations leave the row alone
    always_comb
    begin
        ctrl     = '0;
        ok       = 1'b0;
        rd_front = 1'b0;
        rd_rear  = 1'b0;
        cnt_next = cnt_reg;
        case (req.operation)
            dq_pkg::OP_PUSH_FRONT:
            begin
                ok = !full;
                ctrl.push_front = accept && !full;
            end
            dq_pkg::OP_PUSH_REAR:
            begin
                ok = !full;
                ctrl.push_rear = accept && !full;
            end
            dq_pkg::OP_POP_FRONT:
            begin
                ok = !empty;
                rd_front = !empty;
                ctrl.pop_front = accept && !empty;
            end
            dq_pkg::OP_POP_REAR:
            begin
                ok = !empty;
                rd_rear = !empty;
                ctrl.pop_rear = accept && !empty;
            end
            dq_pkg::OP_PEEK_FRONT:
            begin
                ok = !empty;
                rd_front = !empty;
            end
            dq_pkg::OP_PEEK_REAR:
            begin
                ok = !empty;
                rd_rear = !empty;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (ctrl.push_front || ctrl.push_rear)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (ctrl.pop_front || ctrl.pop_rear)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // Neighbor links: entry 0 is the push word offered as an occupied cell,
    // entry i+1 mirrors cell i, the last entry is a free cell past the rear
    assign chain_valid[0]       = 1'b1;
    assign chain_data[0]        = push_data;
    assign chain_valid[DEPTH+1] = 1'b0;
    assign chain_data[DEPTH+1]  = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (chain_valid[i]),
            .prev_data  (chain_data[i]),
            .next_valid (chain_valid[i+2]),
            .next_data  (chain_data[i+2]),
            .push_data  (push_data),
            .valid      (cell_valid[i]),
            .data       (cell_data[i]),
            .last       (cell_last[i])
        );
        assign chain_valid[i+1] = cell_valid[i];
        assign chain_data[i+1]  = cell_data[i];
    end

    // Rear word: and-or over the single cell flagged as last
    always_comb
    begin
        rear_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_data = rear_data | (cell_data[i] & {DW{cell_last[i]}});
        end
    end

    always_comb
    begin
        rd_data = '0;
        if (rd_front)
        begin
            rd_data = cell_data[0];
        end
        else if (rd_rear)
        begin
            rd_data = rear_data;
        end
    end

    assign rd_ext = 64'(rd_data);
    assign new_rsp.success    = ok;
    assign new_rsp.read_value = rd_ext[dq_pkg::WORD_W-1:0];
    assign new_rsp.occupancy  = dq_pkg::OCC_W'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Response stage: output register with a skid register behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || rsp.ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (accept)
            begin
                out_reg <= new_rsp;
            end
        end
        else if (accept)
        begin
            skid_reg <= new_rsp;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.success    = out_reg.success;
    assign rsp.read_value = out_reg.read_value;
    assign rsp.occupancy  = out_reg.occupancy;

    // Element count tracks the occupied cells
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == CW'($countones(cell_valid)))
        else $error("element count differs from occupied cells");

    // Occupied cells form one run starting at the front
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
        else $error("occupied cells not contiguous from the front");

    // At most one cell marks the rear
    a_one_rear: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_last))
        else $error("more than one rear cell");

    // Skid register only holds a response behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register filled while output register empty");

    // A refused request returns a zero word
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.success) |-> (rsp.read_value == '0))
        else $error("refused request returned a nonzero word");

endmodule

`default_nettype wire

FILE: hw/rtl/dq_cell.sv
// One storage cell of the queue row: holds one word and a valid bit.
`default_nettype none

module dq_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dq_pkg::dq_ctrl_t                ctrl,
    input  wire logic                            prev_valid,
    input  wire logic [dq_pkg::DATA_WIDTH-1:0]   prev_data,
    input  wire logic                            next_valid,
    input  wire logic [dq_pkg::DATA_WIDTH-1:0]   next_data,
    input  wire logic [dq_pkg::DATA_WIDTH-1:0]   push_data,
    output logic                                 valid,
    output logic [dq_pkg::DATA_WIDTH-1:0]        data,
    output logic                                 last
);

    logic                            valid_reg;
    logic                            valid_next;
    logic [dq_pkg::DATA_WIDTH-1:0]   data_reg;
    logic [dq_pkg::DATA_WIDTH-1:0]   data_next;

    // Front pushes shift toward the rear, front pops shift toward the front;
    // rear operations touch only the boundary between occupied and free cells.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.push_front)
        begin
            valid_next = prev_valid;
            data_next  = prev_data;
        end
        else if (ctrl.pop_front)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (ctrl.push_rear)
        begin
            if (prev_valid && !valid_reg)
            begin
                valid_next = 1'b1;
                data_next  = push_data;
            end
        end
        else if (ctrl.pop_rear)
        begin
            if (valid_reg && !next_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;
    assign last  = valid_reg && !next_valid;

endmodule

`default_nettype wire

FILE: test/dq_checker.sv
`timescale 1ns / 100ps
// Checker for the double-ended queue: predicts every response from the requests and compares.
module dq_checker
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dq_req_if    req,
    dq_rsp_if    rsp,
    output int   mismatch_count,
    output int   outstanding,
    output int   responses_checked,
    output int   full_refusals,
    output int   empty_refusals,
    output int   ignored_ops
);

    localparam int IDX_W = $clog2(DEPTH);

    // One response as the queue should return it
    typedef struct packed {
        logic              success;
        logic [WORD_W-1:0] read_value;
        logic [OCC_W-1:0]  occupancy;
    } deque_reply_t;

    // Shadow copy of the ring
    logic [DATA_WIDTH-1:0] slot_words [DEPTH];
    logic [IDX_W-1:0]      head_slot;
    logic [CNT_W-1:0]      stored_count;

    deque_reply_t replies_due [$];

    initial
    begin
        mismatch_count    = 0;
        responses_checked = 0;
        full_refusals     = 0;
        empty_refusals    = 0;
        ignored_ops       = 0;
    end

    // Ring position a given distance behind the front
    function automatic logic [IDX_W-1:0] slot_at(input int offset);
        return IDX_W'((int'(head_slot) + offset) % DEPTH);
    endfunction

    // Apply one request to the shadow deque and return the response it earns
    function automatic deque_reply_t apply_request(input logic [OP_W-1:0] op,
                                                   input logic [WORD_W-1:0] value);
        deque_reply_t     reply;
        logic [IDX_W-1:0] idx;
        reply = '0;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (stored_count >= DEPTH)
                begin
                    full_refusals++;
                end
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head_slot = slot_at(DEPTH - 1);
                        slot_words[head_slot] = value[DATA_WIDTH-1:0];
                    end
                    else
                    begin
                        slot_words[slot_at(stored_count)] = value[DATA_WIDTH-1:0];
                    end
                    stored_count++;
                    reply.success = 1'b1;
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
            begin
                if (stored_count == 0)
                begin
                    empty_refusals++;
                end
                else
                begin
                    if (op == OP_POP_FRONT || op == OP_PEEK_FRONT)
                        idx = head_slot;
                    else
                        idx = slot_at(stored_count - 1);
                    reply.read_value = WORD_W'(slot_words[idx]);
                    // pops also remove the word; a front pop moves the head
                    if (op == OP_POP_FRONT)
                        head_slot = slot_at(1);
                    if (op == OP_POP_FRONT || op == OP_POP_REAR)
                        stored_count--;
                    reply.success = 1'b1;
                end
            end
            default:
            begin
                ignored_ops++;
            end
        endcase
        reply.occupancy = OCC_W'(stored_count);
        return reply;
    endfunction

    function automatic void compare_field(input string field, input logic [WORD_W-1:0] want,
                                          input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endfunction

    // Retire responses against the oldest prediction, then record new requests
    always @(posedge clk or negedge rst_n)
    begin
        deque_reply_t want;
        if (!rst_n)
        begin
            head_slot    = '0;
            stored_count = '0;
            replies_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: response with none expected: success %0b value 0x%0h occ %0d",
                             $time, rsp.success, rsp.read_value, rsp.occupancy);
                end
                else
                begin
                    want = replies_due.pop_front();
                    compare_field("success", WORD_W'(want.success), WORD_W'(rsp.success));
                    compare_field("read_value", want.read_value, rsp.read_value);
                    compare_field("occupancy", WORD_W'(want.occupancy), WORD_W'(rsp.occupancy));
                    responses_checked++;
                end
            end
            if (req.valid && req.ready)
                replies_due.push_back(apply_request(req.operation, req.push_value));
            outstanding <= replies_due.size();
        end
    end

endmodule

FILE: test/double_ended_queue_tb.sv
`timescale 1ns / 100ps
// Testbench top for the double-ended queue: clock, reset, request traffic and verdict.
module double_ended_queue_tb;
    import dq_pkg::*;

    // Codes outside the operation set; the queue must ignore them
    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

    localparam int HOLD_CYCLES      = 60;
    localparam int RANDOM_PER_PHASE = 130;

    logic clk;
    logic rst_n;

    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_toggle;
    logic hold_seen;
    int   hold_left;
    int   requests_sent;

    int mismatch_count;
    int outstanding;
    int responses_checked;
    int full_refusals;
    int empty_refusals;
    int ignored_ops;

    dq_req_if req_ch ();
    dq_rsp_if rsp_ch ();

    double_ended_queue dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    dq_checker deque_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req_ch),
        .rsp               (rsp_ch),
        .mismatch_count    (mismatch_count),
        .outstanding       (outstanding),
        .responses_checked (responses_checked),
        .full_refusals     (full_refusals),
        .empty_refusals    (empty_refusals),
        .ignored_ops       (ignored_ops)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("%0t: run limit reached with %0d responses outstanding", $time, outstanding);
        $display("*** FAILED ***");
        $finish;
    end

    // Response side: random stalls, plus a long hold-off when the toggle flips
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request, with random idle cycles first, and wait for acceptance
    task automatic send_request(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.push_value <= value;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    // Stop sending until every predicted response has come back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // fill_pct steers the mix toward pushes or toward pops
    function automatic logic [OP_W-1:0] pick_op(input int fill_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return $urandom_range(1) ? OP_RESERVED_LO : OP_RESERVED_HI;
        else if (roll < 3 + fill_pct)
            return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
        else if ($urandom_range(9) < 7)
            return $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
        else
            return $urandom_range(1) ? OP_PEEK_FRONT : OP_PEEK_REAR;
    endfunction

    // Bursts that lean toward filling or draining, so full and empty both recur
    task automatic run_random(input int count);
        int fill_pct;
        int burst_left;
        fill_pct   = 50;
        burst_left = 0;
        repeat (count)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 8);
                fill_pct   = $urandom_range(1) ? 65 : 20;
            end
            burst_left--;
            send_request(pick_op(fill_pct), pick_word());
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_PEEK_FRONT;
        req_ch.push_value = '0;
        rsp_ch.ready      = 1'b0;
        hold_toggle       = 1'b0;
        hold_seen         = 1'b0;
        hold_left         = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        requests_sent     = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue: every read refused, reserved codes ignored
        send_request(OP_POP_FRONT, '1);
        send_request(OP_POP_REAR, '1);
        send_request(OP_PEEK_FRONT, '0);
        send_request(OP_PEEK_REAR, '0);
        send_request(OP_RESERVED_LO, 32'h1234_5678);
        send_request(OP_RESERVED_HI, '1);

        // Both ends, extreme words
        send_request(OP_PUSH_FRONT, '1);
        send_request(OP_PUSH_REAR, '0);
        send_request(OP_PUSH_FRONT, 32'hA5A5_A5A5);
        send_request(OP_PEEK_FRONT, '0);
        send_request(OP_PEEK_REAR, '0);
        send_request(OP_POP_REAR, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_FRONT, '0);
        send_request(OP_POP_REAR, '0);
        wait_drained();

        // Response side holds off while pushes keep coming: input backs up,
        // then the queue fills and the last pushes are refused
        hold_toggle <= ~hold_toggle;
        repeat (20) send_request(OP_PUSH_REAR, pick_word());
        send_request(OP_PUSH_FRONT, 32'h5A5A_5A5A);
        send_request(OP_RESERVED_HI, '0);
        send_request(OP_PEEK_FRONT, '0);
        send_request(OP_PEEK_REAR, '0);
        wait_drained();

        // Random traffic under each idle pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct   = 80;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 80;
                end
                default:
                begin
                    send_idle_pct   = 22;
                    recv_stall_pct <= 22;
                end
            endcase
            run_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        // Catch any stray response before the verdict
        repeat (5) @(posedge clk);

        $display("Sent %0d requests, checked %0d responses under four idle patterns.",
                 requests_sent, responses_checked);
        $display("Refused: %0d pushes on full, %0d reads on empty; %0d reserved codes ignored.",
                 full_refusals, empty_refusals, ignored_ops);
        if (mismatch_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: double_ended_queue.f
hw/rtl/dq_pkg.sv
hw/rtl/dq_req_if.sv
hw/rtl/dq_rsp_if.sv
hw/rtl/dq_cell.sv
hw/rtl/double_ended_queue.sv
test/dq_checker.sv
test/double_ended_queue_tb.sv
